>>> rtl/bo4_pkg.sv
// shared types, codes and helpers for the best-of-four int8 block encoder
`timescale 1ns / 1ps

package bo4_pkg;

	localparam int NW = 32;
	localparam int IDX_W = 5;
	localparam int FILL_W = 6;
	localparam int GROUP_SIZE = 4;
	localparam int NUM_GROUPS = NW / GROUP_SIZE;
	localparam int SIZE_LIMIT = 33;
	localparam int RAW_SIZE = 1 + NW;
	localparam int BITMAP_HEADER_BITS = 48;
	localparam int ADAPT_HEADER_BITS = 19;
	// bitmap size is 38 - mode count
	localparam int BM_BASE = (BITMAP_HEADER_BITS + NW * 8) / 8;
	// adaptive size is 4*r + 3
	localparam int AD_BASE = (ADAPT_HEADER_BITS + 7) / 8;
	localparam int AD_MUL = NW / 8;
	// group size is (103 + 3*sum of widths) / 8
	localparam int GR_BASE = 8 + NUM_GROUPS * 11 + 7;

	localparam logic [7:0] TAG_RAW = 8'h0A;
	localparam logic [7:0] TAG_BITMAP = 8'h0B;
	localparam logic [7:0] TAG_GROUP = 8'h0C;
	localparam logic [7:0] TAG_ADAPT = 8'h0D;

	localparam logic [1:0] METH_RAW = 2'd0;
	localparam logic [1:0] METH_BITMAP = 2'd1;
	localparam logic [1:0] METH_GROUP = 2'd2;
	localparam logic [1:0] METH_ADAPT = 2'd3;

	typedef enum logic [3:0] {
		K_TAG, K_MODE, K_MCALC, K_MASK, K_BMW, K_RAW,
		K_GHEAD, K_GOFF, K_AHEAD, K_AOFF
	} kind_t;

	typedef struct packed {
		logic             load;
		logic             inc;
		logic             decide;
		logic             push;
		logic             drain;
		logic             clear;
		kind_t            kind;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic       full;
		logic       pack_empty;
		logic [1:0] method;
	} st_t;

	// smallest b >= 1 with 2^b > span, at most 9
	function automatic logic [3:0] width_for(input logic [8:0] span);
		logic [3:0] b;
		b = 4'd1;
		for (int k = 1; k <= 8; k++) begin
			if (span >= (9'd1 << k))
				b = b + 4'd1;
		end
		return b;
	endfunction

endpackage

>>> rtl/bo4_ctrl.sv
// controller: load sequencing, method decision step and emission walk
`timescale 1ns / 1ps

module bo4_ctrl import bo4_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  st_t  st,
	output cmd_t cmd
);

	typedef enum logic [2:0] {S_LOAD, S_INC, S_DECIDE, S_EMIT, S_DRAIN} state_t;
	typedef enum logic [3:0] {
		SG_TAG, SG_MODE, SG_MCALC, SG_MASK, SG_BMW, SG_RAW, SG_GROUP, SG_AHEAD, SG_AOFF
	} seg_t;

	state_t           state_q;
	seg_t             seg_q;
	logic [IDX_W-1:0] idx_q;
	logic             ph_q;
	logic             busy_q;
	logic [IDX_W-1:0] seg_last;
	seg_t             seg_next;
	logic             seg_done;

	assign busy = busy_q;

	always_comb begin
		unique case (seg_q)
			SG_TAG, SG_MODE, SG_AHEAD: seg_last = '0;
			SG_MASK:                   seg_last = IDX_W'(NW / 8 - 1);
			default:                   seg_last = IDX_W'(NW - 1);
		endcase
	end

	// segment order per method; seg_done ends the walk
	always_comb begin
		seg_next = SG_TAG;
		seg_done = 1'b0;
		unique case (seg_q)
			SG_TAG: begin
				unique case (st.method)
					METH_RAW:    seg_next = SG_RAW;
					METH_BITMAP: seg_next = SG_MODE;
					METH_GROUP:  seg_next = SG_GROUP;
					default:     seg_next = SG_AHEAD;
				endcase
			end
			SG_MODE:  seg_next = SG_MCALC;
			SG_MCALC: seg_next = SG_MASK;
			SG_MASK:  seg_next = SG_BMW;
			SG_AHEAD: seg_next = SG_AOFF;
			default:  seg_done = 1'b1;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.load = (state_q == S_LOAD) && start;
		cmd.inc = (state_q == S_INC);
		cmd.decide = (state_q == S_DECIDE);
		cmd.push = (state_q == S_EMIT) && ph_q;
		cmd.drain = (state_q == S_DRAIN);
		cmd.clear = (state_q == S_DRAIN) && st.pack_empty;
		cmd.idx = idx_q;
		unique case (seg_q)
			SG_TAG:   cmd.kind = K_TAG;
			SG_MODE:  cmd.kind = K_MODE;
			SG_MCALC: cmd.kind = K_MCALC;
			SG_MASK:  cmd.kind = K_MASK;
			SG_BMW:   cmd.kind = K_BMW;
			SG_RAW:   cmd.kind = K_RAW;
			SG_GROUP: cmd.kind = (idx_q[1:0] == 2'd0) ? K_GHEAD : K_GOFF;
			SG_AHEAD: cmd.kind = K_AHEAD;
			default:  cmd.kind = K_AOFF;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			seg_q <= SG_TAG;
			idx_q <= '0;
			ph_q <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (start) begin
						state_q <= S_INC;
						busy_q <= 1'b1;
					end
				end
				S_INC: begin
					if (st.full) begin
						state_q <= S_DECIDE;
					end else begin
						state_q <= S_LOAD;
						busy_q <= 1'b0;
					end
				end
				S_DECIDE: begin
					state_q <= S_EMIT;
					seg_q <= SG_TAG;
					idx_q <= '0;
					ph_q <= 1'b0;
				end
				S_EMIT: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (idx_q == seg_last) begin
							idx_q <= '0;
							if (seg_done)
								state_q <= S_DRAIN;
							else
								seg_q <= seg_next;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				S_DRAIN: begin
					if (st.pack_empty) begin
						state_q <= S_LOAD;
						busy_q <= 1'b0;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

>>> rtl/bo4_datapath.sv
// datapath: weight store, value counts, statistics, size compare and bit packer
`timescale 1ns / 1ps

module bo4_datapath import bo4_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  logic [7:0] weight,
	output st_t        st,
	output logic [7:0] out_byte,
	output logic [5:0] byte_index,
	output logic [1:0] method,
	output logic [5:0] block_size,
	output logic       last_byte,
	output logic       result_strobe
);

	// all values are kept biased (weight + 128), which keeps the order
	logic [7:0] wb;
	assign wb = {~weight[7], weight[6:0]};

	logic [7:0]        store_mem [NW];
	logic [7:0]        rd_q;
	logic [5:0]        cnt_mem [256];
	logic [5:0]        cnt_rd_q;
	logic [255:0]      cnt_vld_q;
	logic              vld_rd_q;
	logic [7:0]        wb_q;
	logic [FILL_W-1:0] fill_q;
	logic [7:0]        min_q, max_q;
	logic [5:0]        best_cnt_q;
	logic [7:0]        best_idx_q;
	logic [7:0]        gbase_q, mabs_q;
	logic              grp_end_q;
	logic [2:0]        grp_no_q;
	logic [3:0]        gw_q [NUM_GROUPS];
	logic [6:0]        sumb_q;
	logic              gbad_q;
	logic [1:0]        method_q;
	logic [5:0]        size_q;
	logic [3:0]        r_q;
	logic [7:0]        ebase_q;
	logic [NW-1:0]     mask_q;
	logic [23:0]       acc_q;
	logic [4:0]        pcnt_q;
	logic [5:0]        ocnt_q;
	logic [7:0]        obyte_q;
	logic [5:0]        oidx_q;
	logic              olast_q, ostb_q;

	logic [5:0] cnt_new;
	logic [7:0] adiff;
	logic [3:0] gb_raw, gb;
	assign cnt_new = (vld_rd_q ? cnt_rd_q : 6'd0) + 6'd1;
	assign adiff = (wb >= gbase_q) ? (wb - gbase_q) : (gbase_q - wb);
	assign gb_raw = width_for({mabs_q, 1'b0});
	assign gb = (gb_raw > 4'd8) ? 4'd8 : gb_raw;

	// memories
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			store_mem[fill_q[IDX_W-1:0]] <= wb;
			cnt_rd_q <= cnt_mem[wb];
			wb_q <= wb;
		end
		if (cmd.inc)
			cnt_mem[wb_q] <= cnt_new;
		rd_q <= store_mem[cmd.idx];
	end

	// size of each candidate
	logic [3:0] r_w;
	logic [5:0] bm_size, gr_size, ad_size, sel_s;
	logic [8:0] gr_bits;
	logic [1:0] sel_m;
	always_comb begin
		r_w = width_for({1'b0, max_q - min_q});
		bm_size = 6'(BM_BASE) - best_cnt_q;
		gr_bits = 9'(GR_BASE) + 9'(sumb_q) + 9'({sumb_q, 1'b0});
		gr_size = gr_bits[8:3];
		ad_size = 6'(AD_MUL) * {2'b0, r_w} + 6'(AD_BASE);
		sel_s = 6'(RAW_SIZE);
		sel_m = METH_RAW;
		if (bm_size < 6'(SIZE_LIMIT) && bm_size < sel_s) begin
			sel_s = bm_size;
			sel_m = METH_BITMAP;
		end
		if (gr_size < sel_s) begin
			sel_s = gr_size;
			sel_m = METH_GROUP;
		end
		if (ad_size < 6'(SIZE_LIMIT) && ad_size < sel_s) begin
			sel_s = ad_size;
			sel_m = METH_ADAPT;
		end
		if (sel_m == METH_GROUP && gbad_q) begin
			sel_s = 6'(RAW_SIZE);
			sel_m = METH_RAW;
		end
	end

	// field for the current emission step
	logic [3:0]        cb;
	logic signed [9:0] gs, ghalf, gtop;
	logic [10:0]       fval;
	logic [3:0]        flen;
	logic [7:0]        tag;
	always_comb begin
		cb = gw_q[cmd.idx[IDX_W-1:2]];
		ghalf = 10'sd1 <<< (cb - 4'd1);
		gtop = (10'sd1 <<< cb) - 10'sd1;
		gs = $signed({2'b0, rd_q}) - $signed({2'b0, ebase_q}) + ghalf;
		if (gs < 10'sd0)
			gs = 10'sd0;
		else if (gs > gtop)
			gs = gtop;
		case (method_q)
			METH_RAW:    tag = TAG_RAW;
			METH_BITMAP: tag = TAG_BITMAP;
			METH_GROUP:  tag = TAG_GROUP;
			default:     tag = TAG_ADAPT;
		endcase
		fval = '0;
		flen = '0;
		case (cmd.kind)
			K_TAG: begin
				fval = {3'b0, tag};
				flen = 4'd8;
			end
			K_MODE: begin
				fval = {3'b0, best_idx_q};
				flen = 4'd8;
			end
			K_MASK: begin
				fval = {3'b0, mask_q[cmd.idx[1:0]*8 +: 8]};
				flen = 4'd8;
			end
			K_BMW: begin
				if (rd_q != best_idx_q) begin
					fval = {3'b0, rd_q};
					flen = 4'd8;
				end
			end
			K_RAW: begin
				fval = {3'b0, rd_q};
				flen = 4'd8;
			end
			K_GHEAD: begin
				fval = {cb[2:0], rd_q};
				flen = 4'd11;
			end
			K_GOFF: begin
				fval = 11'(gs[7:0]);
				flen = cb;
			end
			K_AHEAD: begin
				fval = {r_q[2:0], min_q};
				flen = 4'd11;
			end
			K_AOFF: begin
				fval = {3'b0, rd_q - min_q};
				flen = r_q;
			end
			default: begin
				fval = '0;
				flen = '0;
			end
		endcase
	end

	// packer: one byte out per cycle at most
	logic        emit;
	logic [23:0] acc_sh;
	logic [4:0]  pcnt_sh;
	assign emit = (pcnt_q >= 5'd8) || (cmd.drain && pcnt_q != 5'd0);
	always_comb begin
		acc_sh = emit ? (acc_q >> 8) : acc_q;
		if (!emit)
			pcnt_sh = pcnt_q;
		else if (pcnt_q >= 5'd8)
			pcnt_sh = pcnt_q - 5'd8;
		else
			pcnt_sh = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
			vld_rd_q <= 1'b0;
			fill_q <= '0;
			min_q <= 8'hFF;
			max_q <= 8'h00;
			best_cnt_q <= '0;
			best_idx_q <= '0;
			grp_end_q <= 1'b0;
			sumb_q <= '0;
			gbad_q <= 1'b0;
			method_q <= METH_RAW;
			size_q <= '0;
			acc_q <= '0;
			pcnt_q <= '0;
			ocnt_q <= '0;
			ostb_q <= 1'b0;
		end else begin
			ostb_q <= emit;
			if (cmd.load) begin
				vld_rd_q <= cnt_vld_q[wb];
				fill_q <= fill_q + FILL_W'(1);
				if (wb < min_q)
					min_q <= wb;
				if (wb > max_q)
					max_q <= wb;
				grp_end_q <= (fill_q[1:0] == 2'd3);
			end
			if (cmd.inc) begin
				cnt_vld_q[wb_q] <= 1'b1;
				if (cnt_new > best_cnt_q || (cnt_new == best_cnt_q && wb_q < best_idx_q)) begin
					best_cnt_q <= cnt_new;
					best_idx_q <= wb_q;
				end
				if (grp_end_q) begin
					sumb_q <= sumb_q + 7'(gb);
					if (gb == 4'd8)
						gbad_q <= 1'b1;
				end
			end
			if (cmd.decide) begin
				method_q <= sel_m;
				size_q <= sel_s;
			end
			if (cmd.push) begin
				acc_q <= acc_sh | (24'(fval) << pcnt_sh);
				pcnt_q <= pcnt_sh + 5'(flen);
			end else begin
				acc_q <= acc_sh;
				pcnt_q <= pcnt_sh;
			end
			if (emit)
				ocnt_q <= ocnt_q + 6'd1;
			if (cmd.clear) begin
				cnt_vld_q <= '0;
				fill_q <= '0;
				min_q <= 8'hFF;
				max_q <= 8'h00;
				best_cnt_q <= '0;
				best_idx_q <= '0;
				sumb_q <= '0;
				gbad_q <= 1'b0;
				ocnt_q <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			grp_no_q <= fill_q[IDX_W-1:2];
			if (fill_q[1:0] == 2'd0) begin
				gbase_q <= wb;
				mabs_q <= '0;
			end else if (adiff > mabs_q) begin
				mabs_q <= adiff;
			end
		end
		if (cmd.inc && grp_end_q)
			gw_q[grp_no_q] <= gb;
		if (cmd.decide)
			r_q <= r_w;
		if (cmd.push && cmd.kind == K_GHEAD)
			ebase_q <= rd_q;
		if (cmd.push && cmd.kind == K_MCALC)
			mask_q[cmd.idx] <= (rd_q != best_idx_q);
		obyte_q <= acc_q[7:0];
		oidx_q <= ocnt_q;
		olast_q <= (ocnt_q == size_q - 6'd1);
	end

	assign st.full = fill_q[FILL_W-1];
	assign st.pack_empty = (pcnt_q == 5'd0);
	assign st.method = method_q;

	assign out_byte = obyte_q;
	assign byte_index = oidx_q;
	assign method = method_q;
	assign block_size = size_q;
	assign last_byte = olast_q;
	assign result_strobe = ostb_q;

endmodule

>>> rtl/int8_block_best_of_four_encoder.sv
// top level of the best-of-four int8 block encoder
`timescale 1ns / 1ps

// Takes 32 signed 8-bit weights, one transaction each (start high while busy
// is low), and after the 32nd emits the shortest of four packed encodings
// (raw 0x0A, bitmap 0x0B, group of four 0x0C, adaptive 0x0D), one byte per
// result_strobe pulse, tag byte first, with byte_index, method, block_size and
// last_byte alongside. The receiver cannot stall: every byte shows for exactly
// one cycle and must be taken then. Each weight transaction is accepted, then
// its value count in a 256-entry memory gets a read-modify-write. After the
// last weight a decision step picks the method, then the emission walk does
// each packed field as a store read, then a push into the bit packer (for
// bitmap: tag, mode, 32 mask-bit steps, 4 mask bytes, 32 weights); then the
// packer drains. busy stays high through all of that. A group-of-four win in
// which any group needs width 8 or more goes out as raw instead.

module int8_block_best_of_four_encoder import bo4_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] weight,
	output logic       result_strobe,
	output logic [7:0] out_byte,
	output logic [5:0] byte_index,
	output logic [1:0] method,
	output logic [5:0] block_size,
	output logic       last_byte
);

	// command and status between sequencer and datapath
	cmd_t cmd;
	st_t  st;

	bo4_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	bo4_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.weight        (weight),
		.st            (st),
		.out_byte      (out_byte),
		.byte_index    (byte_index),
		.method        (method),
		.block_size    (block_size),
		.last_byte     (last_byte),
		.result_strobe (result_strobe)
	);

endmodule

>>> tb/bo4_checker.sv
// checker for the best-of-four block encoder: predicts and compares output bytes
`timescale 1ns / 1ps

module bo4_checker import bo4_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [7:0] weight,
	input  logic       result_strobe,
	input  logic [7:0] out_byte,
	input  logic [5:0] byte_index,
	input  logic [1:0] method,
	input  logic [5:0] block_size,
	input  logic       last_byte,
	output int         fail_count,
	output int         pending
);

	typedef struct packed {
		logic [7:0] data;
		logic [5:0] idx;
		logic [1:0] meth;
		logic [5:0] size;
		logic       last;
	} enc_byte_t;

	enc_byte_t expected_bytes[$];
	int blk_weights[NW];
	int val_counts[256];
	int fill, wmin, wmax;

	function automatic int span_width(int span);
		int b;
		b = 1;
		while (b < 9 && (1 << b) <= span)
			b++;
		return b;
	endfunction

	function automatic int grp_width(int g);
		int d, mx;
		mx = 0;
		for (int j = 1; j < GROUP_SIZE; j++) begin
			d = blk_weights[g*GROUP_SIZE+j] - blk_weights[g*GROUP_SIZE];
			if (d < 0)
				d = -d;
			if (d > mx)
				mx = d;
		end
		d = span_width(2 * mx);
		return d > 8 ? 8 : d;
	endfunction

	task automatic pack(ref logic [7:0] buff[48], input int pos, input int val, input int n);
		for (int i = 0; i < n; i++)
			if (((val >> i) & 1) && ((pos + i) >> 3) < 48)
				buff[(pos+i)>>3][(pos+i)&7] = 1'b1;
	endtask

	task automatic encode_block();
		logic [7:0] buff[48];
		int mode_i, mode_c, bm_sz, gbits, gr_sz, aw, ad_sz, sz, meth, pos, b, s, top;
		bit grp_ok;
		logic [31:0] mask;
		enc_byte_t e;
		mode_i = 0; mode_c = 0; grp_ok = 1;
		for (int i = 0; i < 256; i++)
			if (val_counts[i] > mode_c) begin
				mode_c = val_counts[i]; mode_i = i;
			end
		bm_sz = (48 + (NW - mode_c) * 8 + 7) / 8;
		gbits = 8;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			b = grp_width(g);
			if (b > 7)
				grp_ok = 0;
			gbits += 11 + 3 * b;
		end
		gr_sz = (gbits + 7) / 8;
		aw = span_width(wmax - wmin);
		ad_sz = (19 + NW * aw + 7) / 8;
		sz = RAW_SIZE; meth = METH_RAW;
		if (bm_sz < SIZE_LIMIT && bm_sz < sz) begin
			sz = bm_sz; meth = METH_BITMAP;
		end
		if (gr_sz < sz) begin
			sz = gr_sz; meth = METH_GROUP;
		end
		if (aw <= 8 && ad_sz < SIZE_LIMIT && ad_sz < sz) begin
			sz = ad_sz; meth = METH_ADAPT;
		end
		if (meth == METH_GROUP && !grp_ok) begin
			sz = RAW_SIZE; meth = METH_RAW;
		end
		foreach (buff[i])
			buff[i] = '0;
		case (meth)
			METH_RAW: begin
				buff[0] = TAG_RAW;
				for (int i = 0; i < NW; i++)
					buff[1+i] = 8'(blk_weights[i] + 128);
			end
			METH_BITMAP: begin
				buff[0] = TAG_BITMAP;
				buff[1] = 8'(mode_i);
				pos = 48; mask = '0;
				for (int i = 0; i < NW; i++)
					if (blk_weights[i] != mode_i - 128) begin
						mask[i] = 1'b1;
						pack(buff, pos, blk_weights[i] + 128, 8);
						pos += 8;
					end
				pack(buff, 16, int'(mask), 32);
			end
			METH_GROUP: begin
				buff[0] = TAG_GROUP;
				pos = 8;
				for (int g = 0; g < NUM_GROUPS; g++) begin
					b = grp_width(g);
					top = (1 << b) - 1;
					pack(buff, pos, blk_weights[g*GROUP_SIZE] + 128, 8); pos += 8;
					pack(buff, pos, b & 7, 3); pos += 3;
					for (int j = 1; j < GROUP_SIZE; j++) begin
						s = blk_weights[g*GROUP_SIZE+j] - blk_weights[g*GROUP_SIZE]
							+ (1 << (b - 1));
						if (s < 0)
							s = 0;
						if (s > top)
							s = top;
						pack(buff, pos, s, b); pos += b;
					end
				end
			end
			default: begin
				buff[0] = TAG_ADAPT;
				pack(buff, 8, wmin + 128, 8);
				pack(buff, 16, aw & 7, 3);
				pos = 19;
				for (int i = 0; i < NW; i++) begin
					pack(buff, pos, blk_weights[i] - wmin, aw);
					pos += aw;
				end
			end
		endcase
		for (int i = 0; i < sz; i++) begin
			e.data = buff[i]; e.idx = 6'(i); e.meth = 2'(meth);
			e.size = 6'(sz); e.last = (i + 1 == sz);
			expected_bytes.push_back(e);
		end
	endtask

	task automatic clear_counts();
		foreach (val_counts[i])
			val_counts[i] = 0;
		fill = 0; wmin = 127; wmax = -128;
	endtask

	initial begin
		fail_count = 0;
		clear_counts();
	end

	assign pending = expected_bytes.size();

	always @(posedge clk) begin
		int w;
		enc_byte_t e, got;
		if (arst_n) begin
			// output side first: a byte never belongs to a weight taken this edge
			if (result_strobe) begin
				got = '{out_byte, byte_index, method, block_size, last_byte};
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected byte, got %p", $time, got);
					fail_count++;
				end else begin
					e = expected_bytes.pop_front();
					if (got !== e) begin
						$display("%0t: mismatch, expected %p, actual %p", $time, e, got);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				w = $signed(weight);
				blk_weights[fill] = w;
				val_counts[w+128]++;
				if (w < wmin)
					wmin = w;
				if (w > wmax)
					wmax = w;
				fill++;
				if (fill == NW) begin
					encode_block();
					clear_counts();
				end
			end
		end
	end

endmodule

>>> tb/testbench.sv
// testbench top: drives weight transactions into the encoder and gives the verdict
`timescale 1ns / 1ps

module testbench import bo4_pkg::*; ();

	logic clk, arst_n, start, busy, result_strobe, last_byte;
	logic [7:0] weight, out_byte;
	logic [5:0] byte_index, block_size;
	logic [1:0] method;
	int fail_count, pending;
	int cycles;

	int8_block_best_of_four_encoder dut (.*);

	bo4_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// global watchdog: fails the run if it does not finish
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 200000) begin
				$display("FAIL int8_block_best_of_four_encoder");
				$finish;
			end
		end
	end

	// weight patterns for whole blocks, picked to steer each method
	function automatic logic [7:0] pick_weight(int kind, int i, int seed);
		case (kind)
			0: return 8'($urandom);                            // random bytes, raw wins
			1: return ($urandom_range(0, 9) < 8) ? 8'(seed) : 8'($urandom); // bitmap
			2: return 8'(seed + (i / 4) * 37 + $urandom_range(0, 4) - 2);   // group
			3: return 8'(seed + $urandom_range(0, 7));          // adaptive, narrow span
			// group wins but its last group needs width 8, so raw goes out
			4: return 8'((i < 28) ? seed + (i / 4) * 3 :
				(((i % 4) == 0) ? seed : seed + 100));
			default: return 8'(seed + $urandom_range(0, 1));
		endcase
	endfunction

	// one weight transaction; idle gaps at about 34 percent unless burst
	task automatic send_weight(input logic [7:0] w, input bit burst);
		while (!burst && $urandom_range(0, 99) < 34) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		weight <= w;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic send_block(input logic [7:0] ws[NW], input bit burst);
		for (int i = 0; i < NW; i++)
			send_weight(ws[i], burst);
	endtask

	initial begin
		logic [7:0] ws[NW];
		int seed;
		start = 0;
		weight = '0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one block for each of patterns 1 to 4, the group block as a long burst
		for (int b = 1; b <= 4; b++) begin
			seed = $urandom;
			foreach (ws[i]) ws[i] = pick_weight(b, i, seed);
			send_block(ws, b == 2);
		end
		// trailing partial block produces nothing
		for (int i = 0; i < 20; i++)
			send_weight(8'($urandom), 0);
		start <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("PASS int8_block_best_of_four_encoder");
		else
			$display("FAIL int8_block_best_of_four_encoder");
		$finish;
	end

endmodule
